// ===== rtl/xis_pkg.sv =====
// Shared constants, opcode codes, item types and helper functions for the x86 subset step core.
package xis_pkg;

  localparam int unsigned MEM_BYTES_DEF = 1048576;

  localparam logic [31:0] RESET_VECTOR = 32'h0000_7C00;
  localparam logic [15:0] SERIAL_PORT  = 16'h03F8;

  localparam logic [2:0] EAX_IX = 3'd0;
  localparam logic [2:0] EDX_IX = 3'd2;
  localparam logic [2:0] ESP_IX = 3'd4;
  localparam logic [2:0] EBP_IX = 3'd5;

  localparam logic [1:0] STOP_RUN   = 2'd0;
  localparam logic [1:0] STOP_HALT  = 2'd1;
  localparam logic [1:0] STOP_OPC   = 2'd2;
  localparam logic [1:0] STOP_MODRM = 2'd3;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_OPC   = 2'd1;
  localparam logic [1:0] FAULT_MODRM = 2'd2;

  localparam logic CFG_START_PC    = 1'b0;
  localparam logic CFG_START_STACK = 1'b1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  localparam logic [1:0] MOD_IND   = 2'd0;
  localparam logic [1:0] MOD_D8    = 2'd1;
  localparam logic [1:0] MOD_D32   = 2'd2;
  localparam logic [1:0] MOD_REG   = 2'd3;
  localparam logic [2:0] RM_SIB    = 3'd4;
  localparam logic [2:0] RM_DISP32 = 3'd5;

  localparam logic [2:0] SUB_ADD = 3'd0;
  localparam logic [2:0] SUB_SUB = 3'd5;
  localparam logic [2:0] SUB_CMP = 3'd7;
  localparam logic [2:0] SUB_INC = 3'd0;

  localparam logic [7:0] OP_ADD_RM_R    = 8'h01;
  localparam logic [7:0] OP_CMP_R_RM    = 8'h3B;
  localparam logic [7:0] OP_PUSH_R      = 8'h50;
  localparam logic [7:0] OP_POP_R       = 8'h58;
  localparam logic [7:0] OP_PUSH_IMM32  = 8'h68;
  localparam logic [7:0] OP_PUSH_IMM8   = 8'h6A;
  localparam logic [7:0] OP_JCC         = 8'h70;
  localparam logic [7:0] OP_GRP83       = 8'h83;
  localparam logic [7:0] OP_MOV_RM_R    = 8'h89;
  localparam logic [7:0] OP_MOV_R_RM    = 8'h8B;
  localparam logic [7:0] OP_MOV_R_IMM   = 8'hB8;
  localparam logic [7:0] OP_RET         = 8'hC3;
  localparam logic [7:0] OP_MOV_RM_IMM  = 8'hC7;
  localparam logic [7:0] OP_LEAVE       = 8'hC9;
  localparam logic [7:0] OP_CALL        = 8'hE8;
  localparam logic [7:0] OP_JMP32       = 8'hE9;
  localparam logic [7:0] OP_JMP8        = 8'hEB;
  localparam logic [7:0] OP_IN          = 8'hEC;
  localparam logic [7:0] OP_OUT         = 8'hEE;
  localparam logic [7:0] OP_GRPFF       = 8'hFF;

  localparam logic [3:0] CC_O  = 4'h0;
  localparam logic [3:0] CC_NO = 4'h1;
  localparam logic [3:0] CC_C  = 4'h2;
  localparam logic [3:0] CC_NC = 4'h3;
  localparam logic [3:0] CC_Z  = 4'h4;
  localparam logic [3:0] CC_NZ = 4'h5;
  localparam logic [3:0] CC_S  = 4'h8;
  localparam logic [3:0] CC_NS = 4'h9;
  localparam logic [3:0] CC_L  = 4'hC;
  localparam logic [3:0] CC_LE = 4'hE;

  typedef struct packed {
    logic        mode;
    logic [19:0] load_address;
    logic [7:0]  load_byte;
    logic [7:0]  port_in_byte;
  } item_t;

  typedef struct packed {
    logic        port_out_valid;
    logic [7:0]  port_out_byte;
    logic        port_in_used;
    logic        halted;
    logic [1:0]  fault;
    logic [31:0] pc;
    logic [3:0]  flags;
    logic [31:0] accumulator;
  } result_t;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // flags of a - b: {overflow, sign, zero, carry}
  function automatic logic [3:0] sub_flags(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    r = a - b;
    return {((a[31] ^ b[31]) & (a[31] ^ r[31])), r[31], (r == 32'd0), (a < b)};
  endfunction

endpackage

// ===== rtl/xis_in_if.sv =====
// Input channel interface: valid/ready handshake with the load or step item payload.
interface xis_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [19:0] load_address;
  logic [7:0]  load_byte;
  logic [7:0]  port_in_byte;

  modport source (output valid, output mode, output load_address, output load_byte,
                  output port_in_byte, input ready);
  modport sink   (input valid, input mode, input load_address, input load_byte,
                  input port_in_byte, output ready);
endinterface

// ===== rtl/xis_out_if.sv =====
// Result channel interface: valid/ready handshake with the per-item result payload.
interface xis_out_if;
  logic        valid;
  logic        ready;
  logic        port_out_valid;
  logic [7:0]  port_out_byte;
  logic        port_in_used;
  logic        halted;
  logic [1:0]  fault;
  logic [31:0] pc;
  logic [3:0]  flags;
  logic [31:0] accumulator;

  modport source (output valid, output port_out_valid, output port_out_byte,
                  output port_in_used, output halted, output fault, output pc,
                  output flags, output accumulator, input ready);
  modport sink   (input valid, input port_out_valid, input port_out_byte,
                  input port_in_used, input halted, input fault, input pc,
                  input flags, input accumulator, output ready);
endinterface

// ===== rtl/x86_subset_instruction_step_core.sv =====
// Top level: x86 subset interpreter, front queue plus byte-serial fetch/execute back end.
// A load, or a step on a stopped core, goes straight to the result state; a step fetches the
// instruction bytes one by one on the single byte-wide memory port, then decodes, reads memory or
// the stack when needed, executes, writes memory or the stack when needed and returns its result.
// The back end works on one transaction at a time; the front queue holds two waiting items.
// Reset: a clearing pass writes every memory byte to zero, no input taken.
module x86_subset_instruction_step_core #(
  parameter int unsigned MEM_BYTES = xis_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  xis_in_if.sink      in_ch,
  xis_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  xis_pkg::item_t q_item;
  logic           q_valid, q_pop, front_en;

  xis_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (front_en),
    .in_ch  (in_ch),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_pop  (q_pop)
  );

  xis_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .front_en (front_en),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/xis_ram.sv =====
// Generic single-port RAM with registered read data.
module xis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/xis_front.sv =====
// Front end: accepts input transactions into a two-entry queue ahead of the executor.
module xis_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  xis_in_if.sink        in_ch,
  output xis_pkg::item_t q_item,
  output logic          q_valid,
  input  logic          q_pop
);

  xis_pkg::item_t ent_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r;
  logic           push;

  assign in_ch.ready = en && (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_item      = ent_r[rptr_r];
  assign q_valid     = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= '{mode: in_ch.mode, load_address: in_ch.load_address,
                         load_byte: in_ch.load_byte, port_in_byte: in_ch.port_in_byte};
    end
  end

endmodule

// ===== rtl/xis_back.sv =====
// Back end: fetches, decodes and executes one instruction per step transaction over byte memory.
module xis_back #(
  parameter int unsigned MEM_BYTES = xis_pkg::MEM_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  xis_pkg::item_t q_item,
  input  logic           q_valid,
  output logic           q_pop,
  output logic           front_en,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  xis_out_if.source      out_ch
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_FETCH  = 4'd2;
  localparam logic [3:0] S_DECODE = 4'd3;
  localparam logic [3:0] S_RDMEM  = 4'd4;
  localparam logic [3:0] S_EXEC   = 4'd5;
  localparam logic [3:0] S_WRITE  = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;

  localparam logic [3:0] FETCH_LEN = 4'd10;

  logic [3:0]       state_r;
  logic [3:0]       cnt_r;
  logic [AW-1:0]    clr_r;
  logic [31:0]      regs_r [8];
  logic [31:0]      pc_r;
  logic [3:0]       flags_r;
  logic [1:0]       stop_r;
  xis_pkg::item_t   item_r;
  logic [7:0]       ib_r [10];
  logic [7:0]       mb_r [4];
  logic [31:0]      ea_r, rdaddr_r;
  logic [2:0]       len_r;
  logic [1:0]       dfault_r;
  logic [31:0]      waddr_r, wdata_r;
  logic             pv_r, pin_r;
  logic [7:0]       pb_r;
  xis_pkg::result_t out_r;
  logic             out_valid_r;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;

  xis_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // ---------------- decode ----------------
  logic [7:0]  op;
  logic [1:0]  md;
  logic [2:0]  rg, rm;
  logic [31:0] disp32;
  logic        has_modrm, is_push_r, is_pop_r, is_jcc, is_movi, jcc_known, op_known;
  logic [31:0] d_ea;
  logic [2:0]  d_len;
  logic [1:0]  d_fault;
  logic        d_need_rd;
  logic [31:0] d_rdaddr;

  assign op        = ib_r[0];
  assign md        = ib_r[1][7:6];
  assign rg        = ib_r[1][5:3];
  assign rm        = ib_r[1][2:0];
  assign disp32    = {ib_r[5], ib_r[4], ib_r[3], ib_r[2]};
  assign is_push_r = (op[7:3] == xis_pkg::OP_PUSH_R[7:3]);
  assign is_pop_r  = (op[7:3] == xis_pkg::OP_POP_R[7:3]);
  assign is_movi   = (op[7:3] == xis_pkg::OP_MOV_R_IMM[7:3]);
  assign is_jcc    = (op[7:4] == xis_pkg::OP_JCC[7:4]);
  assign has_modrm = (op == xis_pkg::OP_ADD_RM_R) || (op == xis_pkg::OP_CMP_R_RM) ||
                     (op == xis_pkg::OP_GRP83) || (op == xis_pkg::OP_MOV_RM_R) ||
                     (op == xis_pkg::OP_MOV_R_RM) || (op == xis_pkg::OP_MOV_RM_IMM) ||
                     (op == xis_pkg::OP_GRPFF);
  assign jcc_known = (op[3:0] == xis_pkg::CC_O) || (op[3:0] == xis_pkg::CC_NO) ||
                     (op[3:0] == xis_pkg::CC_C) || (op[3:0] == xis_pkg::CC_NC) ||
                     (op[3:0] == xis_pkg::CC_Z) || (op[3:0] == xis_pkg::CC_NZ) ||
                     (op[3:0] == xis_pkg::CC_S) || (op[3:0] == xis_pkg::CC_NS) ||
                     (op[3:0] == xis_pkg::CC_L) || (op[3:0] == xis_pkg::CC_LE);
  assign op_known  = has_modrm || is_push_r || is_pop_r || is_movi || (is_jcc && jcc_known) ||
                     (op == xis_pkg::OP_PUSH_IMM32) || (op == xis_pkg::OP_PUSH_IMM8) ||
                     (op == xis_pkg::OP_RET) || (op == xis_pkg::OP_LEAVE) ||
                     (op == xis_pkg::OP_CALL) || (op == xis_pkg::OP_JMP32) ||
                     (op == xis_pkg::OP_JMP8) || (op == xis_pkg::OP_IN) ||
                     (op == xis_pkg::OP_OUT);

  always_comb begin
    d_ea  = 32'd0;
    d_len = 3'd1;
    if (has_modrm) begin
      unique case (md)
        xis_pkg::MOD_IND: begin
          if (rm == xis_pkg::RM_DISP32) begin
            d_ea  = disp32;
            d_len = 3'd6;
          end else begin
            d_ea  = regs_r[rm];
            d_len = 3'd2;
          end
        end
        xis_pkg::MOD_D8: begin
          d_ea  = regs_r[rm] + xis_pkg::sext8(ib_r[2]);
          d_len = 3'd3;
        end
        xis_pkg::MOD_D32: begin
          d_ea  = regs_r[rm] + disp32;
          d_len = 3'd6;
        end
        default: d_len = 3'd2;
      endcase
    end
  end

  always_comb begin
    d_fault = xis_pkg::STOP_RUN;
    if (has_modrm) begin
      if ((md != xis_pkg::MOD_REG) && (rm == xis_pkg::RM_SIB)) begin
        d_fault = xis_pkg::STOP_MODRM;
      end
      if ((op == xis_pkg::OP_GRP83) && (rg != xis_pkg::SUB_ADD) &&
          (rg != xis_pkg::SUB_SUB) && (rg != xis_pkg::SUB_CMP)) begin
        d_fault = xis_pkg::STOP_MODRM;
      end
      if ((op == xis_pkg::OP_GRPFF) && (rg != xis_pkg::SUB_INC)) begin
        d_fault = xis_pkg::STOP_MODRM;
      end
    end else if (!op_known) begin
      d_fault = xis_pkg::STOP_OPC;
    end
  end

  always_comb begin
    d_rdaddr = d_ea;
    if (op == xis_pkg::OP_LEAVE) begin
      d_rdaddr = regs_r[xis_pkg::EBP_IX];
    end else if (is_pop_r || (op == xis_pkg::OP_RET)) begin
      d_rdaddr = regs_r[xis_pkg::ESP_IX];
    end
    d_need_rd = (d_fault == xis_pkg::STOP_RUN) &&
                ((has_modrm && (md != xis_pkg::MOD_REG)) || is_pop_r ||
                 (op == xis_pkg::OP_RET) || (op == xis_pkg::OP_LEAVE));
  end

  // ---------------- execute ----------------
  logic [31:0] mem32, imm32_1, imm8_1, imm8_l, imm32_l, rmv, sp, len32;
  logic [3:0]  li;
  logic        take, fc, fz, fs, fo;
  logic [31:0] x_pc;
  logic [3:0]  x_flags;
  logic        a_en, b_en, x_wr, x_pv, x_pin;
  logic [2:0]  a_ix;
  logic [31:0] a_val, b_val, x_waddr, x_wdata, wval;
  logic        wrm;
  logic [7:0]  x_pb;

  assign mem32   = {mb_r[3], mb_r[2], mb_r[1], mb_r[0]};
  assign imm32_1 = {ib_r[4], ib_r[3], ib_r[2], ib_r[1]};
  assign imm8_1  = xis_pkg::sext8(ib_r[1]);
  assign li      = {1'b0, len_r};
  assign imm8_l  = xis_pkg::sext8(ib_r[li]);
  assign imm32_l = {ib_r[li + 4'd3], ib_r[li + 4'd2], ib_r[li + 4'd1], ib_r[li]};
  assign rmv     = (md == xis_pkg::MOD_REG) ? regs_r[rm] : mem32;
  assign sp      = regs_r[xis_pkg::ESP_IX];
  assign len32   = {29'd0, len_r};
  assign {fo, fs, fz, fc} = flags_r;

  always_comb begin
    unique case (op[3:0])
      xis_pkg::CC_O:  take = fo;
      xis_pkg::CC_NO: take = !fo;
      xis_pkg::CC_C:  take = fc;
      xis_pkg::CC_NC: take = !fc;
      xis_pkg::CC_Z:  take = fz;
      xis_pkg::CC_NZ: take = !fz;
      xis_pkg::CC_S:  take = fs;
      xis_pkg::CC_NS: take = !fs;
      xis_pkg::CC_L:  take = (fs != fo);
      xis_pkg::CC_LE: take = fz || (fs != fo);
      default:        take = 1'b0;
    endcase
  end

  always_comb begin
    x_pc    = pc_r + len32;
    x_flags = flags_r;
    a_en    = 1'b0;
    a_ix    = rg;
    a_val   = 32'd0;
    b_en    = 1'b0;
    b_val   = 32'd0;
    x_wr    = 1'b0;
    x_waddr = ea_r;
    x_wdata = 32'd0;
    wval    = 32'd0;
    wrm     = 1'b0;
    x_pv    = 1'b0;
    x_pb    = 8'd0;
    x_pin   = 1'b0;
    priority if (is_movi) begin
      a_en  = 1'b1;
      a_ix  = op[2:0];
      a_val = imm32_1;
      x_pc  = pc_r + 32'd5;
    end else if (is_push_r) begin
      b_en    = 1'b1;
      b_val   = sp - 32'd4;
      x_wr    = 1'b1;
      x_waddr = sp - 32'd4;
      x_wdata = regs_r[op[2:0]];
    end else if (is_pop_r) begin
      // a pop into esp keeps the popped value, so skip the stack bump
      b_en  = (op[2:0] != xis_pkg::ESP_IX);
      b_val = sp + 32'd4;
      a_en  = 1'b1;
      a_ix  = op[2:0];
      a_val = mem32;
    end else if (is_jcc) begin
      x_pc = pc_r + 32'd2 + (take ? imm8_1 : 32'd0);
    end else begin
      unique case (op)
        xis_pkg::OP_ADD_RM_R: begin
          wval = rmv + regs_r[rg];
          wrm  = 1'b1;
        end
        xis_pkg::OP_CMP_R_RM: x_flags = xis_pkg::sub_flags(regs_r[rg], rmv);
        xis_pkg::OP_PUSH_IMM32, xis_pkg::OP_PUSH_IMM8, xis_pkg::OP_CALL: begin
          b_en    = 1'b1;
          b_val   = sp - 32'd4;
          x_wr    = 1'b1;
          x_waddr = sp - 32'd4;
          if (op == xis_pkg::OP_PUSH_IMM8) begin
            x_wdata = imm8_1;
            x_pc    = pc_r + 32'd2;
          end else if (op == xis_pkg::OP_PUSH_IMM32) begin
            x_wdata = imm32_1;
            x_pc    = pc_r + 32'd5;
          end else begin
            x_wdata = pc_r + 32'd5;
            x_pc    = pc_r + 32'd5 + imm32_1;
          end
        end
        xis_pkg::OP_GRP83: begin
          x_pc = pc_r + len32 + 32'd1;
          if (rg == xis_pkg::SUB_ADD) begin
            wval = rmv + imm8_l;
            wrm  = 1'b1;
          end else begin
            x_flags = xis_pkg::sub_flags(rmv, imm8_l);
            if (rg == xis_pkg::SUB_SUB) begin
              wval = rmv - imm8_l;
              wrm  = 1'b1;
            end
          end
        end
        xis_pkg::OP_MOV_RM_R: begin
          wval = regs_r[rg];
          wrm  = 1'b1;
        end
        xis_pkg::OP_MOV_R_RM: begin
          a_en  = 1'b1;
          a_val = rmv;
        end
        xis_pkg::OP_RET: begin
          x_pc  = mem32;
          b_en  = 1'b1;
          b_val = sp + 32'd4;
        end
        xis_pkg::OP_MOV_RM_IMM: begin
          wval = imm32_l;
          wrm  = 1'b1;
          x_pc = pc_r + len32 + 32'd4;
        end
        xis_pkg::OP_LEAVE: begin
          b_en  = 1'b1;
          b_val = regs_r[xis_pkg::EBP_IX] + 32'd4;
          a_en  = 1'b1;
          a_ix  = xis_pkg::EBP_IX;
          a_val = mem32;
        end
        xis_pkg::OP_JMP32: x_pc = pc_r + 32'd5 + imm32_1;
        xis_pkg::OP_JMP8:  x_pc = pc_r + 32'd2 + imm8_1;
        xis_pkg::OP_IN: begin
          a_en  = 1'b1;
          a_ix  = xis_pkg::EAX_IX;
          x_pin = (regs_r[xis_pkg::EDX_IX][15:0] == xis_pkg::SERIAL_PORT);
          a_val = {regs_r[xis_pkg::EAX_IX][31:8], x_pin ? item_r.port_in_byte : 8'd0};
        end
        xis_pkg::OP_OUT: begin
          x_pv = (regs_r[xis_pkg::EDX_IX][15:0] == xis_pkg::SERIAL_PORT);
          x_pb = x_pv ? regs_r[xis_pkg::EAX_IX][7:0] : 8'd0;
        end
        xis_pkg::OP_GRPFF: begin
          wval = rmv + 32'd1;
          wrm  = 1'b1;
        end
        default: x_pc = pc_r;
      endcase
    end
    if (wrm) begin
      if (md == xis_pkg::MOD_REG) begin
        a_en  = 1'b1;
        a_ix  = rm;
        a_val = wval;
      end else begin
        x_wr    = 1'b1;
        x_waddr = ea_r;
        x_wdata = wval;
      end
    end
  end

  // ---------------- memory port ----------------
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(pc_r + {28'd0, cnt_r});
    ram_wdata = 8'd0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
      end
      S_IDLE: begin
        ram_we    = q_valid && (q_item.mode == xis_pkg::MODE_LOAD);
        ram_addr  = AW'(q_item.load_address);
        ram_wdata = q_item.load_byte;
      end
      S_RDMEM: ram_addr = AW'(rdaddr_r + {28'd0, cnt_r});
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = AW'(waddr_r + {28'd0, cnt_r});
        ram_wdata = wdata_r[{cnt_r[1:0], 3'b000} +: 8];
      end
      default: ;
    endcase
  end

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign front_en = (state_r != S_CLEAR);

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= 4'd0;
      pc_r        <= xis_pkg::RESET_VECTOR;
      flags_r     <= 4'd0;
      stop_r      <= xis_pkg::STOP_RUN;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= (3'(i) == xis_pkg::ESP_IX) ? xis_pkg::RESET_VECTOR : 32'd0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt_r <= 4'd0;
          if (q_valid) begin
            if ((q_item.mode == xis_pkg::MODE_STEP) && (stop_r == xis_pkg::STOP_RUN)) begin
              state_r <= S_FETCH;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_FETCH: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == FETCH_LEN) begin
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          cnt_r <= 4'd0;
          if (d_need_rd) begin
            state_r <= S_RDMEM;
          end else begin
            state_r <= S_EXEC;
          end
        end
        S_RDMEM: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd4) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt_r <= 4'd0;
          if (dfault_r != xis_pkg::STOP_RUN) begin
            stop_r  <= dfault_r;
            state_r <= S_FIN;
          end else begin
            pc_r    <= x_pc;
            flags_r <= x_flags;
            if (x_pc == 32'd0) begin
              stop_r <= xis_pkg::STOP_HALT;
            end
            if (b_en) begin
              regs_r[xis_pkg::ESP_IX] <= b_val;
            end
            if (a_en) begin
              regs_r[a_ix] <= a_val;
            end
            state_r <= x_wr ? S_WRITE : S_FIN;
          end
        end
        S_WRITE: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd3) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_we) begin
        if (cfg_index == xis_pkg::CFG_START_PC) begin
          pc_r <= cfg_data;
        end else begin
          regs_r[xis_pkg::ESP_IX] <= cfg_data;
        end
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        item_r <= q_item;
        pv_r   <= 1'b0;
        pb_r   <= 8'd0;
        pin_r  <= 1'b0;
      end
      S_FETCH: begin
        if (cnt_r != 4'd0) begin
          ib_r[cnt_r - 4'd1] <= ram_rdata;
        end
      end
      S_DECODE: begin
        ea_r      <= d_ea;
        len_r     <= d_len;
        dfault_r  <= d_fault;
        rdaddr_r  <= d_rdaddr;
      end
      S_RDMEM: begin
        if (cnt_r != 4'd0) begin
          mb_r[2'(cnt_r - 4'd1)] <= ram_rdata;
        end
      end
      S_EXEC: begin
        waddr_r   <= x_waddr;
        wdata_r   <= x_wdata;
        if (dfault_r == xis_pkg::STOP_RUN) begin
          pv_r  <= x_pv;
          pb_r  <= x_pb;
          pin_r <= x_pin;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_r.port_out_valid <= pv_r;
          out_r.port_out_byte  <= pb_r;
          out_r.port_in_used   <= pin_r;
          out_r.halted         <= (stop_r == xis_pkg::STOP_HALT);
          out_r.fault          <= (stop_r == xis_pkg::STOP_OPC)   ? xis_pkg::FAULT_OPC :
                                  (stop_r == xis_pkg::STOP_MODRM) ? xis_pkg::FAULT_MODRM :
                                                                    xis_pkg::FAULT_NONE;
          out_r.pc             <= pc_r;
          out_r.flags          <= flags_r;
          out_r.accumulator    <= regs_r[xis_pkg::EAX_IX];
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.port_out_valid = out_r.port_out_valid;
  assign out_ch.port_out_byte  = out_r.port_out_byte;
  assign out_ch.port_in_used   = out_r.port_in_used;
  assign out_ch.halted         = out_r.halted;
  assign out_ch.fault          = out_r.fault;
  assign out_ch.pc             = out_r.pc;
  assign out_ch.flags          = out_r.flags;
  assign out_ch.accumulator    = out_r.accumulator;

endmodule

// ===== tb/sv/xis_step_checker.sv =====
// Checker for the x86 subset step core: predicts each result and compares it.
module xis_step_checker (
  input  logic        clk,
  input  logic        rst_n,
  xis_in_if           in_ch,
  xis_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import xis_pkg::*;

  localparam int unsigned MEM = MEM_BYTES_DEF;

  logic [7:0]  mem_img [MEM];
  logic [31:0] gpr [8];
  logic [31:0] pc_q;
  logic [3:0]  flg;
  logic [1:0]  run_st;
  result_t     expected_q [$];

  initial begin
    errors = 0;
    pending = 0;
    foreach (mem_img[i]) mem_img[i] = 8'h00;
  end

  function automatic logic [7:0] rd8(logic [31:0] a);
    return mem_img[a % MEM];
  endfunction

  function automatic logic [31:0] rd32(logic [31:0] a);
    return {rd8(a + 32'd3), rd8(a + 32'd2), rd8(a + 32'd1), rd8(a)};
  endfunction

  function automatic void wr32(logic [31:0] a, logic [31:0] v);
    for (int i = 0; i < 4; i++) mem_img[(a + i) % MEM] = v[8*i +: 8];
  endfunction

  function automatic logic [31:0] sx8(logic [7:0] b);
    return b[7] ? {24'hFFFFFF, b} : {24'h0, b};
  endfunction

  function automatic void push_word(logic [31:0] v);
    gpr[ESP_IX] = gpr[ESP_IX] - 32'd4;
    wr32(gpr[ESP_IX], v);
  endfunction

  function automatic logic [31:0] pop_word();
    logic [31:0] v;
    v = rd32(gpr[ESP_IX]);
    gpr[ESP_IX] = gpr[ESP_IX] + 32'd4;
    return v;
  endfunction

  // {overflow, sign, zero, carry} of a - b, borrow taken from a 33-bit difference
  function automatic logic [3:0] borrow_flags(logic [31:0] a, logic [31:0] b);
    logic [32:0] d;
    d = {1'b0, a} - {1'b0, b};
    return {(a[31] != b[31]) && (d[31] != a[31]), d[31], d[31:0] == 32'd0, d[32]};
  endfunction

  task automatic run_item(input item_t it, output result_t r);
    logic [7:0]  op, m;
    logic [1:0]  md, flt;
    logic [2:0]  rg, rmi;
    logic [31:0] ea, len, rmv, nxt, wval, imm, pc;
    logic        has_modrm, wrm, take, known, c, z, s, o;
    r = '0;
    if (it.mode == MODE_LOAD) begin
      mem_img[it.load_address % MEM] = it.load_byte;
    end else if (run_st == STOP_RUN) begin
      pc = pc_q;
      op = rd8(pc);
      has_modrm = op inside {OP_ADD_RM_R, OP_CMP_R_RM, OP_GRP83, OP_MOV_RM_R, OP_MOV_R_RM,
                             OP_MOV_RM_IMM, OP_GRPFF};
      flt = STOP_RUN; len = 1; md = 0; rg = 0; rmi = 0; ea = 0; rmv = 0; wrm = 0; wval = 0;
      if (has_modrm) begin
        m = rd8(pc + 1);
        md = m[7:6]; rg = m[5:3]; rmi = m[2:0];
        len = 2;
        if (md != MOD_REG && rmi == RM_SIB) flt = STOP_MODRM;
        else if (md == MOD_IND && rmi == RM_DISP32) begin
          ea = rd32(pc + 2); len = 6;
        end else if (md == MOD_IND) ea = gpr[rmi];
        else if (md == MOD_D8) begin
          ea = gpr[rmi] + sx8(rd8(pc + 2)); len = 3;
        end else if (md == MOD_D32) begin
          ea = gpr[rmi] + rd32(pc + 2); len = 6;
        end
        if (op == OP_GRP83 && !(rg inside {SUB_ADD, SUB_SUB, SUB_CMP})) flt = STOP_MODRM;
        if (op == OP_GRPFF && rg != SUB_INC) flt = STOP_MODRM;
        if (flt == STOP_RUN) rmv = (md == MOD_REG) ? gpr[rmi] : rd32(ea);
      end
      nxt = pc + len;
      if (flt == STOP_RUN) begin
        if (op[7:3] == OP_MOV_R_IMM[7:3]) begin
          gpr[op[2:0]] = rd32(pc + 1); nxt = pc + 5;
        end else if (op[7:3] == OP_PUSH_R[7:3]) begin
          push_word(gpr[op[2:0]]);
        end else if (op[7:3] == OP_POP_R[7:3]) begin
          wval = pop_word();
          gpr[op[2:0]] = wval;
          wval = 0;
        end else if (op[7:4] == OP_JCC[7:4]) begin
          {o, s, z, c} = flg;
          known = 1; take = 0;
          case (op[3:0])
            CC_O:  take = o;
            CC_NO: take = !o;
            CC_C:  take = c;
            CC_NC: take = !c;
            CC_Z:  take = z;
            CC_NZ: take = !z;
            CC_S:  take = s;
            CC_NS: take = !s;
            CC_L:  take = (s != o);
            CC_LE: take = z || (s != o);
            default: known = 0;
          endcase
          if (!known) flt = STOP_OPC;
          else nxt = pc + 2 + (take ? sx8(rd8(pc + 1)) : 32'd0);
        end else begin
          case (op)
            OP_ADD_RM_R: begin wval = rmv + gpr[rg]; wrm = 1; end
            OP_CMP_R_RM: flg = borrow_flags(gpr[rg], rmv);
            OP_PUSH_IMM32: begin push_word(rd32(pc + 1)); nxt = pc + 5; end
            OP_PUSH_IMM8: begin push_word(sx8(rd8(pc + 1))); nxt = pc + 2; end
            OP_GRP83: begin
              imm = sx8(rd8(pc + len));
              nxt = pc + len + 1;
              if (rg == SUB_ADD) begin
                wval = rmv + imm; wrm = 1;
              end else if (rg == SUB_SUB) begin
                wval = rmv - imm; wrm = 1; flg = borrow_flags(rmv, imm);
              end else flg = borrow_flags(rmv, imm);
            end
            OP_MOV_RM_R: begin wval = gpr[rg]; wrm = 1; end
            OP_MOV_R_RM: gpr[rg] = rmv;
            OP_RET: nxt = pop_word();
            OP_MOV_RM_IMM: begin wval = rd32(pc + len); wrm = 1; nxt = pc + len + 4; end
            OP_LEAVE: begin
              gpr[ESP_IX] = gpr[EBP_IX];
              gpr[EBP_IX] = pop_word();
            end
            OP_CALL: begin push_word(pc + 5); nxt = pc + 5 + rd32(pc + 1); end
            OP_JMP32: nxt = pc + 5 + rd32(pc + 1);
            OP_JMP8: nxt = pc + 2 + sx8(rd8(pc + 1));
            OP_IN: begin
              imm = 0;
              if (gpr[EDX_IX][15:0] == SERIAL_PORT) begin
                imm = {24'h0, it.port_in_byte}; r.port_in_used = 1;
              end
              gpr[EAX_IX] = {gpr[EAX_IX][31:8], imm[7:0]};
            end
            OP_OUT:
              if (gpr[EDX_IX][15:0] == SERIAL_PORT) begin
                r.port_out_valid = 1; r.port_out_byte = gpr[EAX_IX][7:0];
              end
            OP_GRPFF: begin wval = rmv + 1; wrm = 1; end
            default: flt = STOP_OPC;
          endcase
        end
      end
      if (flt != STOP_RUN) run_st = flt;
      else begin
        if (wrm) begin
          if (md == MOD_REG) gpr[rmi] = wval;
          else wr32(ea, wval);
        end
        pc_q = nxt;
        if (pc_q == 32'd0) run_st = STOP_HALT;
      end
    end
    r.halted = (run_st == STOP_HALT);
    r.fault = (run_st == STOP_OPC) ? FAULT_OPC : (run_st == STOP_MODRM) ? FAULT_MODRM : FAULT_NONE;
    r.pc = pc_q;
    r.flags = flg;
    r.accumulator = gpr[EAX_IX];
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    item_t   it;
    result_t r, w;
    if (!rst_n) begin
      foreach (gpr[i]) gpr[i] = 32'd0;
      gpr[ESP_IX] = RESET_VECTOR;
      pc_q = RESET_VECTOR;
      flg = 4'd0;
      run_st = STOP_RUN;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_START_PC) pc_q = cfg_data;
        else gpr[ESP_IX] = cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        it = '{in_ch.mode, in_ch.load_address, in_ch.load_byte, in_ch.port_in_byte};
        run_item(it, r);
        expected_q.push_back(r);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $realtime);
          errors++;
        end else begin
          w = expected_q.pop_front();
          if (out_ch.port_out_valid !== w.port_out_valid)
            report("port_out_valid", out_ch.port_out_valid, w.port_out_valid);
          if (out_ch.port_out_byte !== w.port_out_byte)
            report("port_out_byte", out_ch.port_out_byte, w.port_out_byte);
          if (out_ch.port_in_used !== w.port_in_used)
            report("port_in_used", out_ch.port_in_used, w.port_in_used);
          if (out_ch.halted !== w.halted) report("halted", out_ch.halted, w.halted);
          if (out_ch.fault !== w.fault) report("fault", out_ch.fault, w.fault);
          if (out_ch.pc !== w.pc) report("pc", out_ch.pc, w.pc);
          if (out_ch.flags !== w.flags) report("flags", out_ch.flags, w.flags);
          if (out_ch.accumulator !== w.accumulator)
            report("accumulator", out_ch.accumulator, w.accumulator);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// ===== tb/sv/x86_subset_instruction_step_core_tb.sv =====
// Testbench top: builds small x86 programs, loads and steps them, and gives the verdict.
module x86_subset_instruction_step_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xis_pkg::*;

  localparam int LIMIT = 6_000_000;
  localparam int NKIND = 18;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending;

  xis_in_if  in_ch ();
  xis_out_if out_ch ();

  x86_subset_instruction_step_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  xis_step_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  int   gap_pct, stall_pct, hold_left, cycles;
  bit   hold_req;
  int   sent, recv, n_steps, n_loads, n_progs;
  logic [7:0]  code [$];
  logic [31:0] org;
  int   nins;
  logic [3:0] cc_list [10] = '{CC_O, CC_NO, CC_C, CC_NC, CC_Z, CC_NZ, CC_S, CC_NS, CC_L, CC_LE};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 0;
    hold_req = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 0;
      end else out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (out_ch.valid && out_ch.ready) recv++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("x86_subset_instruction_step_core test failed");
      $finish;
    end
  end

  task automatic send_item(logic m, logic [19:0] a, logic [7:0] b, logic [7:0] p);
    in_ch.valid <= 1;
    in_ch.mode <= m;
    in_ch.load_address <= a;
    in_ch.load_byte <= b;
    in_ch.port_in_byte <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    if (m == MODE_STEP) n_steps++; else n_loads++;
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sent != recv) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void emit32(logic [31:0] v);
    for (int i = 0; i < 4; i++) code.push_back(v[8*i +: 8]);
  endfunction

  function automatic void emit_modrm(logic [2:0] rg);
    logic [1:0] md;
    logic [2:0] rmi;
    md = 2'($urandom_range(3));
    rmi = 3'($urandom_range(7));
    if (md != MOD_REG && rmi == RM_SIB) rmi = RM_DISP32;
    code.push_back({md, rg, rmi});
    if (md == MOD_IND && rmi == RM_DISP32)
      emit32($urandom_range(1) ? {12'h0, 2'b10, 18'($urandom)} : pick32());
    else if (md == MOD_D8) code.push_back(8'($urandom));
    else if (md == MOD_D32) emit32(pick32());
  endfunction

  function automatic void emit_insn(int kind);
    logic [2:0] r;
    int n;
    r = 3'($urandom_range(7));
    nins++;
    case (kind)
      0: begin code.push_back(OP_MOV_R_IMM | r); emit32(pick32()); end
      1: code.push_back(OP_PUSH_R | r);
      2: code.push_back(OP_POP_R | r);
      3: begin code.push_back(OP_PUSH_IMM32); emit32(pick32()); end
      4: begin code.push_back(OP_PUSH_IMM8); code.push_back(8'($urandom)); end
      5: begin code.push_back(OP_ADD_RM_R); emit_modrm(r); end
      6: begin code.push_back(OP_CMP_R_RM); emit_modrm(r); end
      7: begin code.push_back(OP_MOV_RM_R); emit_modrm(r); end
      8: begin code.push_back(OP_MOV_R_RM); emit_modrm(r); end
      9: begin code.push_back(OP_MOV_RM_IMM); emit_modrm(r); emit32(pick32()); end
      10: begin
        code.push_back(OP_GRP83);
        case ($urandom_range(2))
          0: emit_modrm(SUB_ADD);
          1: emit_modrm(SUB_SUB);
          default: emit_modrm(SUB_CMP);
        endcase
        code.push_back(8'($urandom));
      end
      11: begin code.push_back(OP_GRPFF); emit_modrm(SUB_INC); end
      12: begin
        // either path lands on valid code: skip or run the filler move
        code.push_back(OP_JCC | {4'h0, cc_list[$urandom_range(9)]});
        code.push_back(8'd5);
        emit_insn(0);
      end
      13: begin
        n = $urandom_range(6);
        if ($urandom_range(1)) begin
          code.push_back(OP_JMP8); code.push_back(8'(n));
        end else begin
          code.push_back(OP_JMP32); emit32(32'(n));
        end
        repeat (n) code.push_back(8'($urandom));
      end
      14:
        if ($urandom_range(1)) begin
          code.push_back(OP_CALL); emit32(0);
          code.push_back(OP_GRP83); code.push_back({MOD_REG, SUB_ADD, ESP_IX});
          code.push_back(8'd4);
          nins++;
        end else begin
          code.push_back(OP_PUSH_IMM32); emit32(org + code.size() + 5);
          code.push_back(OP_RET);
          nins++;
        end
      15: code.push_back(OP_LEAVE);
      default: begin
        if ($urandom_range(2) != 0) begin
          code.push_back(OP_MOV_R_IMM | EDX_IX);
          emit32({$urandom_range(1) ? 16'($urandom) : 16'h0, SERIAL_PORT});
          nins++;
        end
        code.push_back(kind == 16 ? OP_IN : OP_OUT);
      end
    endcase
  endfunction

  // stop_kind: -1 none, 0 halt, 1 bad opcode, 2 bad ModRM form
  task automatic run_program(logic [31:0] base, logic [31:0] sp, int n, bit directed,
                             int stop_kind, bit long_hold);
    drain();
    write_cfg(CFG_START_PC, base);
    write_cfg(CFG_START_STACK, sp);
    org = base;
    code.delete();
    nins = 0;
    for (int i = 0; i < n; i++) emit_insn(directed ? i % NKIND : $urandom_range(NKIND - 1));
    nins++;
    case (stop_kind)
      0: begin code.push_back(OP_JMP32); emit32(32'd0 - (org + code.size() + 4)); end
      1: code.push_back($urandom_range(1) ? 8'h0F : 8'h7A);
      2: case ($urandom_range(2))
        0: begin code.push_back(OP_MOV_R_RM); code.push_back({2'($urandom_range(2)), 3'd1, RM_SIB}); end
        1: begin code.push_back(OP_GRP83); code.push_back({MOD_REG, 3'd1, 3'd0}); end
        default: begin code.push_back(OP_GRPFF); code.push_back({MOD_REG, 3'd2, 3'd3}); end
      endcase
      default: begin code.push_back(OP_JMP8); code.push_back(8'hFE); end
    endcase
    if (long_hold) hold_req = 1;
    foreach (code[i]) begin
      if ($urandom_range(9) == 0)
        send_item(MODE_LOAD, {2'b10, 18'($urandom)}, 8'($urandom), 8'($urandom));
      send_item(MODE_LOAD, 20'(org + i), code[i], 8'($urandom));
    end
    // extra steps spin on the closing jump or report the stopped state
    repeat (nins + $urandom_range(1, 3))
      send_item(MODE_STEP, 20'($urandom), 8'($urandom), 8'($urandom));
    if (stop_kind >= 0)
      repeat (3) send_item(MODE_LOAD, 20'($urandom), 8'($urandom), 8'($urandom));
    n_progs++;
  endtask

  initial begin
    int stop_kind;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.mode = 0;
    in_ch.load_address = 0;
    in_ch.load_byte = 0;
    in_ch.port_in_byte = 0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    run_program(RESET_VECTOR, 32'h000C_8000, NKIND, 1, -1, 0);
    run_program(32'h0000_0000, 32'hFFFF_FFFF, 8, 0, -1, 0);
    run_program(32'hFFFF_0000, 32'h0000_0000, 8, 0, -1, 0);
    run_program(32'h000F_FFF8, 32'h000C_1234, 8, 0, -1, 0);
    while (sent < 900) begin
      case (n_progs % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 52; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      run_program({12'h0, 20'($urandom_range(32'h10000, 32'h7FF00))},
                  {12'h0, 20'($urandom_range(32'hC0000, 32'hEFFF0))},
                  $urandom_range(6, 16), 0, -1, n_progs == 6);
    end
    stop_kind = $urandom_range(2);
    run_program(32'h0002_0000, 32'h000D_0000, 4, 0, stop_kind, 0);
    drain();

    $display("Ran %0d programs with %0d instruction steps and %0d memory loads,",
             n_progs, n_steps, n_loads);
    $display("under four idle mixes and a long result stall; closing case %0s.",
             stop_kind == 0 ? "halt" : stop_kind == 1 ? "bad opcode" : "bad ModRM form");
    if (errors == 0 && pending == 0)
      $display("x86_subset_instruction_step_core test passed");
    else
      $display("x86_subset_instruction_step_core test failed");
    $finish;
  end
endmodule
